FILE: rtl/core/bmhs_pkg.sv
// Shared constants and types for the binary min-heap sort core.
package bmhs_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int DATA_W    = 32;
    localparam int IDX_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int CH_W      = IDX_W + 2;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
        logic                     overflowed;
    } res_t;

endpackage

FILE: rtl/core/bmhs_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
module bmhs_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

FILE: rtl/core/bmhs_engine.sv
// Heap sequencer: sift-up on insert, root removal and sift-down on drain.
module bmhs_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [bmhs_pkg::DATA_W-1:0] in_value,
    input  logic                          in_last,
    output logic                          res_valid,
    input  logic                          res_ready,
    output bmhs_pkg::res_t                res
);
    import bmhs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_START,
        S_UP_CMP,
        S_EX_RD,
        S_EX_LD,
        S_EMIT,
        S_DN_ISSUE,
        S_DN_CMP
    } state_t;

    state_t                    state_reg;
    logic [IDX_W-1:0]          pos_reg;
    logic [CNT_W-1:0]          count_reg;
    logic                      drop_reg;
    logic                      last_reg;
    logic signed [DATA_W-1:0]  val_reg;
    logic signed [DATA_W-1:0]  top_reg;

    logic                      mem_we;
    logic [IDX_W-1:0]          mem_waddr;
    logic [DATA_W-1:0]         mem_wdata;
    logic [IDX_W-1:0]          mem_raddr_a;
    logic [IDX_W-1:0]          mem_raddr_b;
    logic [DATA_W-1:0]         mem_rdata_a;
    logic [DATA_W-1:0]         mem_rdata_b;

    logic [IDX_W-1:0]          parent_idx;
    logic [CH_W-1:0]           left_idx;
    logic [CH_W-1:0]           right_idx;
    logic                      left_in;
    logic                      right_in;
    logic                      pick_right;
    logic [IDX_W-1:0]          pick_idx;
    logic signed [DATA_W-1:0]  pick_val;
    logic                      up_swap;
    logic                      dn_swap;

    bmhs_ram #(
        .DEPTH (MAX_ITEMS),
        .WIDTH (DATA_W)
    ) u_ram (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (mem_raddr_a),
        .raddr_b (mem_raddr_b),
        .rdata_a (mem_rdata_a),
        .rdata_b (mem_rdata_b)
    );

    always_comb
    begin
        parent_idx = IDX_W'((pos_reg - 1'b1) >> 1);
        left_idx   = CH_W'({pos_reg, 1'b1});
        right_idx  = left_idx + 1'b1;
        left_in    = left_idx < CH_W'(count_reg);
        right_in   = right_idx < CH_W'(count_reg);
        // prefer the left child unless the right one is strictly smaller
        pick_right = right_in && ($signed(mem_rdata_b) < $signed(mem_rdata_a));
        pick_idx   = pick_right ? right_idx[IDX_W-1:0] : left_idx[IDX_W-1:0];
        pick_val   = pick_right ? $signed(mem_rdata_b) : $signed(mem_rdata_a);
        up_swap    = val_reg < $signed(mem_rdata_a);
        dn_swap    = pick_val < val_reg;
    end

    always_comb
    begin
        mem_we      = 1'b0;
        mem_waddr   = pos_reg;
        mem_wdata   = val_reg;
        mem_raddr_a = parent_idx;
        mem_raddr_b = parent_idx;
        unique case (state_reg)
            S_UP_START:
            begin
                mem_we = (pos_reg == '0);
            end
            S_UP_CMP:
            begin
                mem_we    = 1'b1;
                mem_wdata = up_swap ? mem_rdata_a : val_reg;
            end
            S_EX_RD:
            begin
                mem_raddr_a = '0;
                mem_raddr_b = IDX_W'(count_reg - 1'b1);
            end
            S_DN_ISSUE:
            begin
                mem_we      = !left_in;
                mem_raddr_a = left_idx[IDX_W-1:0];
                mem_raddr_b = right_idx[IDX_W-1:0];
            end
            S_DN_CMP:
            begin
                mem_we    = 1'b1;
                mem_wdata = dn_swap ? pick_val : val_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign in_ready       = (state_reg == S_IDLE);
    assign res_valid      = (state_reg == S_EMIT);
    assign res.value      = top_reg;
    assign res.last       = (count_reg == '0);
    assign res.overflowed = drop_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            drop_reg  <= 1'b0;
            pos_reg   <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        last_reg <= in_last;
                        val_reg  <= in_value;
                        if (count_reg >= CNT_W'(MAX_ITEMS))
                        begin
                            // drop the word, keep the set
                            drop_reg  <= 1'b1;
                            state_reg <= in_last ? S_EX_RD : S_IDLE;
                        end
                        else
                        begin
                            pos_reg   <= IDX_W'(count_reg);
                            count_reg <= count_reg + 1'b1;
                            state_reg <= S_UP_START;
                        end
                    end
                end
                S_UP_START:
                begin
                    if (pos_reg == '0)
                    begin
                        state_reg <= last_reg ? S_EX_RD : S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_UP_CMP;
                    end
                end
                S_UP_CMP:
                begin
                    if (up_swap)
                    begin
                        pos_reg   <= parent_idx;
                        state_reg <= S_UP_START;
                    end
                    else
                    begin
                        state_reg <= last_reg ? S_EX_RD : S_IDLE;
                    end
                end
                S_EX_RD:
                begin
                    state_reg <= S_EX_LD;
                end
                S_EX_LD:
                begin
                    top_reg   <= $signed(mem_rdata_a);
                    val_reg   <= $signed(mem_rdata_b);
                    count_reg <= count_reg - 1'b1;
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (res_ready)
                    begin
                        pos_reg <= '0;
                        if (count_reg == '0)
                        begin
                            drop_reg  <= 1'b0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_DN_ISSUE;
                        end
                    end
                end
                S_DN_ISSUE:
                begin
                    state_reg <= left_in ? S_DN_CMP : S_EX_RD;
                end
                S_DN_CMP:
                begin
                    if (dn_swap)
                    begin
                        pos_reg   <= pick_idx;
                        state_reg <= S_DN_ISSUE;
                    end
                    else
                    begin
                        state_reg <= S_EX_RD;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/core/binary_min_heap_sort_core.sv
// Top level of the binary min-heap sort core: heap engine and output register.
//
// Usage: feed signed 32-bit words on the s_axis channel; s_axis_tlast marks
// the final word of a set. Words without tlast produce nothing. After the
// tlast word is inserted, the held values leave on m_axis in ascending order,
// m_axis_tlast on the largest one. m_axis_tuser is high on every word of a
// set in which words were dropped because the heap (64 entries) was full;
// a dropped tlast word still starts the drain.
// Each insert climbs the heap one level at a time, a parent read and compare
// per level, and stops at the root or when a parent compare ends the climb;
// this parent read/compare loop runs on the single heap RAM.
// Draining reads the root and the last value; the last value of a set is
// emitted without a sift-down, any other value is followed by a sift-down
// paced by the two-port child read, compare and write-back.
// s_axis_tready is low while an insert or a drain is in progress.
// A stalled m_axis holds its word in the output register; the engine waits
// for the slot to free before it removes the next root.
// Reset empties the heap and clears the overflow flag; no clearing pass.
module binary_min_heap_sort_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value_in
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] value_out
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // [0] overflowed
);
    import bmhs_pkg::*;

    logic  res_valid;
    logic  res_ready;
    res_t  res;
    logic  out_valid_reg;
    res_t  out_reg;

    bmhs_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_value  ($signed(s_axis_tdata)),
        .in_last   (s_axis_tlast),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                out_valid_reg <= 1'b1;
                out_reg       <= res;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg.value;
    assign m_axis_tlast  = out_reg.last;
    assign m_axis_tuser  = out_reg.overflowed;

endmodule
